### rtl/core/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding window maximum
// Register map, result width and configuration types.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int OUT_WIDTH      = 32;
  localparam int WIN_REG_WIDTH  = 7;
  localparam int APB_ADDR_WIDTH = 2;
  localparam int APB_DATA_WIDTH = 32;

  typedef logic [APB_ADDR_WIDTH-1:0] apb_addr_t;
  typedef logic [APB_DATA_WIDTH-1:0] apb_data_t;
  typedef logic [WIN_REG_WIDTH-1:0]  win_reg_t;

  localparam apb_addr_t REG_WINDOW_SIZE   = apb_addr_t'(0);
  localparam win_reg_t  WINDOW_SIZE_RESET = win_reg_t'(1);

endpackage

### rtl/core/sliding_window_maximum.sv
// ----------------------------------------------------------------------------
// sliding_window_maximum: running maximum over the latest window_size samples
// A sample is shifted into the candidate chain, and its result then passes the output register.
// Throughput: one sample per clock; a stalled result holds the input only
// while a second result waits behind the output register.
// Reset clears the candidate chain and fill count, window_size returns to 1.
// ----------------------------------------------------------------------------
module sliding_window_maximum #(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  swm_pkg::apb_addr_t                       paddr,
  input  swm_pkg::apb_data_t                       pwdata,
  output swm_pkg::apb_data_t                       prdata,
  output logic                                     pready,
  input  logic                                     sample_valid,
  output logic                                     sample_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]           sample,
  input  logic                                     last_of_sequence,
  output logic                                     result_valid,
  input  logic                                     result_stall,
  output logic signed [swm_pkg::OUT_WIDTH-1:0]     window_max,
  output logic                                     end_of_sequence
);

  import swm_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int WW = (CW > WIN_REG_WIDTH) ? CW : WIN_REG_WIDTH;

  win_reg_t                               window_size;
  logic [WW-1:0]                          ws_ext;
  logic [CW-1:0]                          win_eff;
  logic [CW-1:0]                          fill_count;
  logic [CW-1:0]                          fill_plus;
  logic                                   stale;
  logic                                   pend;
  logic                                   pend_last;
  logic                                   accept;
  logic                                   emit;
  logic                                   move;
  logic [MAX_WINDOW-1:0]                  cand;
  logic [MAX_WINDOW-1:0][SAMPLE_WIDTH-1:0] values;
  logic [SAMPLE_WIDTH-1:0]                front;

  // configuration port
  assign pready = 1'b1;
  assign prdata = apb_data_t'(window_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_WINDOW_SIZE) begin
      window_size <= win_reg_t'(pwdata);
    end
  end

  assign ws_ext  = WW'(window_size);
  assign win_eff = (ws_ext == '0) ? CW'(1) :
                   (ws_ext > WW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : CW'(ws_ext);

  // handshake
  assign move         = pend && (!result_valid || !result_stall);
  assign sample_stall = pend && result_valid && result_stall;
  assign accept       = sample_valid && !sample_stall;

  assign fill_plus = (fill_count < CW'(MAX_WINDOW)) ? fill_count + CW'(1) : fill_count;
  assign emit      = fill_plus >= win_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      stale      <= 1'b0;
    end else if (accept) begin
      fill_count <= last_of_sequence ? '0 : fill_plus;
      // chain is cleared lazily: slots read as empty on the next shift
      stale      <= last_of_sequence;
    end
  end

  // candidate chain, slot i holds the sample of age i
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] prev_value;
    logic                           prev_cand;
    logic signed [SAMPLE_WIDTH-1:0] cell_value;

    if (i == 0) begin : g_head
      assign prev_value = sample;
      assign prev_cand  = 1'b0;
    end else begin : g_body
      assign prev_value = values[i-1];
      assign prev_cand  = cand[i-1] & ~stale;
    end

    swm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift_en   (accept),
      .head       (i == 0),
      .in_window  (CW'(i) < win_eff),
      .sample     (sample),
      .prev_value (prev_value),
      .prev_cand  (prev_cand),
      .value      (cell_value),
      .cand       (cand[i])
    );

    assign values[i] = cell_value;
  end

  swm_select #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_select (
    .cand   (cand),
    .values (values),
    .front  (front)
  );

  // result waiting for the front select
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (accept && emit) begin
      pend <= 1'b1;
    end else if (move) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_last <= last_of_sequence;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (move) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      window_max      <= OUT_WIDTH'(front);
      end_of_sequence <= pend_last;
    end
  end

endmodule

### rtl/core/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell: one age slot of the candidate chain
// Holds the sample of its age and whether that sample is still a candidate
// for the maximum; takes the neighbor's slot on every accepted sample.
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           shift_en,
  input  logic                           head,
  input  logic                           in_window,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic signed [SAMPLE_WIDTH-1:0] prev_value,
  input  logic                           prev_cand,
  output logic signed [SAMPLE_WIDTH-1:0] value,
  output logic                           cand
);

  logic above_sample;
  logic cand_next;

  assign above_sample = prev_value > sample;

  // a slot survives only if still inside the window and not beaten by the new sample
  assign cand_next = head ? 1'b1 : (prev_cand & in_window & above_sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      cand <= 1'b0;
    end else if (shift_en) begin
      cand <= cand_next;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      value <= head ? sample : prev_value;
    end
  end

endmodule

### rtl/core/swm_select.sv
// ----------------------------------------------------------------------------
// swm_select: front of the candidate chain
// Picks the oldest live candidate, which is the window maximum.
// ----------------------------------------------------------------------------
module swm_select #(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic [MAX_WINDOW-1:0]                   cand,
  input  logic [MAX_WINDOW-1:0][SAMPLE_WIDTH-1:0] values,
  output logic [SAMPLE_WIDTH-1:0]                 front
);

  logic [MAX_WINDOW-1:0] onehot;

  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      onehot[i] = cand[i] & ~(|(cand >> (i + 1)));
    end
  end

  always_comb begin
    front = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      front = front | (values[i] & {SAMPLE_WIDTH{onehot[i]}});
    end
  end

endmodule

### verif/tb_sliding_window_maximum.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_window_maximum: self-checking bench for the window maximum block
// Samples go in as bursts with random gaps while the result side stalls at
// random, but for one phase with neither. A deque model predicts every maximum, and each result transaction
// is compared with the oldest prediction. The window register is rewritten
// between phases, the sequence sometimes running across the change.
// ----------------------------------------------------------------------------
module tb_sliding_window_maximum;
  import swm_pkg::*;

  localparam int MAX_WINDOW     = 64;
  localparam int SAMPLE_WIDTH   = 32;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 135;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct {
    sample_t value;
    int      age;
  } candidate_t;

  typedef struct {
    logic signed [OUT_WIDTH-1:0] window_max;
    logic                        end_of_sequence;
  } max_result_t;

  logic      clk;
  logic      rst              = 1'b1;
  logic      psel             = 1'b0;
  logic      penable          = 1'b0;
  logic      pwrite           = 1'b0;
  apb_addr_t paddr            = REG_WINDOW_SIZE;
  apb_data_t pwdata           = '0;
  apb_data_t prdata;
  logic      pready;
  logic      sample_valid     = 1'b0;
  logic      sample_stall;
  sample_t   sample           = '0;
  logic      last_of_sequence = 1'b0;
  logic      result_valid;
  logic      result_stall     = 1'b0;
  logic signed [OUT_WIDTH-1:0] window_max;
  logic      end_of_sequence;

  sliding_window_maximum #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .sample_valid     (sample_valid),
    .sample_stall     (sample_stall),
    .sample           (sample),
    .last_of_sequence (last_of_sequence),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .window_max       (window_max),
    .end_of_sequence  (end_of_sequence)
  );

  // model state
  candidate_t  candidates[$];
  int          model_fill;
  win_reg_t    model_window;
  max_result_t expected_maxima[$];

  int error_count;
  int burst_left;
  int seq_left;
  bit gaps_on;
  bit stall_on;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic predict_window_max(input sample_t s, input logic last);
    int          w;
    candidate_t  c;
    max_result_t r;
    w = (model_window == 0) ? 1 : ((model_window > MAX_WINDOW) ? MAX_WINDOW : model_window);
    foreach (candidates[i])
      if (candidates[i].age < MAX_WINDOW) candidates[i].age++;
    while (candidates.size() > 0 && candidates[0].age >= w) candidates.delete(0);
    // equal older candidates go too
    while (candidates.size() > 0 && candidates[$].value <= s)
      candidates.delete(candidates.size() - 1);
    c.value = s;
    c.age   = 0;
    candidates.insert(candidates.size(), c);
    if (model_fill < MAX_WINDOW) model_fill++;
    if (model_fill >= w) begin
      r.window_max      = candidates[0].value;
      r.end_of_sequence = last;
      expected_maxima.insert(expected_maxima.size(), r);
    end
    if (last) begin
      candidates.delete();
      model_fill = 0;
    end
  endtask

  task automatic send_sample(input sample_t s, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = (!gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        sample_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
    end
    sample_valid     <= 1'b1;
    sample           <= s;
    last_of_sequence <= last;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    predict_window_max(s, last);
    burst_left--;
  endtask

  // wait until every prediction has been matched, then let the pipe settle
  task automatic wait_results_done();
    sample_valid <= 1'b0;
    burst_left = 0;
    while (expected_maxima.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input apb_addr_t addr, input apb_data_t data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_window_reg();
    apb_data_t rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= REG_WINDOW_SIZE;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== apb_data_t'(model_window)) begin
      $display("%0t window_size readback: expected %0d actual %0d", $time, model_window, rd);
      error_count++;
    end
  endtask

  task automatic set_window(input int w);
    wait_results_done();
    apb_write(REG_WINDOW_SIZE, apb_data_t'(w));
    model_window = win_reg_t'(w);
    check_window_reg();
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 5))
      0: return sample_t'(int'($urandom_range(0, 8)) - 4);
      1: return $urandom_range(0, 1) ? {1'b0, {(SAMPLE_WIDTH-1){1'b1}}}
                                     : {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      2: return {1'b0, {(SAMPLE_WIDTH-9){1'b1}}, 8'($urandom)};
      3: return sample_t'(int'($urandom_range(0, 200)) - 100);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // result side: stall runs and free runs, now and then a long free stretch
  always @(posedge clk) begin
    int stall_left;
    int r;
    if (!stall_on) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        result_stall <= 1'b0;
        stall_left = $urandom_range(30, 60);
      end else if (r <= 3) begin
        result_stall <= 1'b1;
        stall_left = $urandom_range(0, 3);
      end else if (r == 4) begin
        result_stall <= 1'b1;
        stall_left = $urandom_range(10, 24);
      end else begin
        result_stall <= 1'b0;
        stall_left = $urandom_range(0, 7);
      end
    end
  end

  always @(posedge clk) begin
    max_result_t e;
    if (!rst && result_valid && !result_stall) begin
      if (expected_maxima.size() == 0) begin
        $display("%0t unexpected result: window_max %0d end_of_sequence %0b",
                 $time, window_max, end_of_sequence);
        error_count++;
      end else begin
        e = expected_maxima[0];
        expected_maxima.delete(0);
        if (window_max !== e.window_max) begin
          $display("%0t window_max: expected %0d actual %0d", $time, e.window_max, window_max);
          error_count++;
        end
        if (end_of_sequence !== e.end_of_sequence) begin
          $display("%0t end_of_sequence: expected %0b actual %0b",
                   $time, e.end_of_sequence, end_of_sequence);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    int quiet_cycles;
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall) ||
        (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic test_register_reset();
    check_window_reg();
  endtask

  // window of one: each result is the sample itself
  task automatic test_extremes();
    send_sample({1'b0, {(SAMPLE_WIDTH-1){1'b1}}}, 1'b0);
    send_sample({1'b1, {(SAMPLE_WIDTH-1){1'b0}}}, 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b1);
  endtask

  task automatic test_equal_and_short();
    set_window(3);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(9, 1'b0);
    send_sample(2, 1'b0);
    send_sample(1, 1'b0);
    send_sample(0, 1'b1);
    // sequence shorter than the window
    set_window(4);
    send_sample(7, 1'b0);
    send_sample(8, 1'b1);
    // zero acts as one
    set_window(0);
    send_sample(3, 1'b0);
    send_sample(-3, 1'b1);
    // above the maximum saturates
    set_window(127);
    send_sample(1, 1'b0);
    send_sample(2, 1'b0);
    send_sample(3, 1'b1);
  endtask

  task automatic test_mid_sequence_window();
    set_window(2);
    send_sample(10, 1'b0);
    send_sample(4, 1'b0);
    send_sample(6, 1'b0);
    set_window(5);
    send_sample(1, 1'b0);
    send_sample(2, 1'b0);
    set_window(1);
    send_sample(-7, 1'b1);
  endtask

  task automatic test_random_phases();
    int w;
    int eff;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: w = 1;
        1: w = MAX_WINDOW;
        2: w = 0;
        3: w = 127;
        4: w = 2;
        default: w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12);
      endcase
      set_window(w);
      eff = (w == 0) ? 1 : ((w > MAX_WINDOW) ? MAX_WINDOW : w);
      gaps_on  = (phase != 5);
      stall_on = (phase != 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (seq_left == 0)
          seq_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, eff)
                                                 : eff + $urandom_range(0, 2 * eff + 8);
        send_sample(pick_sample(), seq_left == 1);
        seq_left--;
        // hold the sender until the result side has caught up
        if (phase == 3 && n == PHASE_ITEMS / 2) wait_results_done();
      end
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    error_count  = 0;
    burst_left   = 0;
    seq_left     = 0;
    gaps_on      = 1'b1;
    stall_on     = 1'b1;
    model_fill   = 0;
    model_window = WINDOW_SIZE_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_reset();
    test_extremes();
    test_equal_and_short();
    test_mid_sequence_window();
    test_random_phases();
    wait_results_done();

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/swm_pkg.sv
rtl/core/swm_cell.sv
rtl/core/swm_select.sv
rtl/core/sliding_window_maximum.sv
verif/tb_sliding_window_maximum.sv
